// File: rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared constants, types and helpers of the FIFO reinsertion cache policy.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int DEPTH    = 1024;
    localparam int KEY_BITS = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int OCC_W    = ADDR_W + 1;

    localparam int IO_KEY_W = 64;
    localparam int CFG_W    = 10;
    localparam logic [CFG_W-1:0] CLEAR_DEPTH_RST = 10'd103;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_EVICT  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [OCC_W-1:0]  t_occ;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RUN,
        S_INS_A,
        S_INS_B,
        S_EV_RD,
        S_EV_CHK,
        S_PR_A,
        S_PR_B,
        S_PR_C,
        S_DONE
    } t_state;

    // ring slot at a given distance behind base
    function automatic t_addr slot_add(input t_addr base, input t_occ off);
        t_occ sum;
        sum = t_occ'(base) + off;
        if (sum >= t_occ'(DEPTH)) begin
            sum = sum - t_occ'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic t_addr slot_prev(input t_addr base);
        t_addr r;
        if (base == '0) begin
            r = t_addr'(DEPTH - 1);
        end else begin
            r = base - t_addr'(1);
        end
        return r;
    endfunction

endpackage

// File: rtl/frc_if.sv
// ----------------------------------------------------------------------------
// frc_if
// Valid/ready channels of the cache policy block: request, result, config.
// ----------------------------------------------------------------------------
interface frc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] key;
    logic        mark_on_hit;
    modport source (output valid, operation, key, mark_on_hit, input ready);
    modport sink   (input valid, operation, key, mark_on_hit, output ready);
endinterface

interface frc_res_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        evicted;
    logic        promoted;
    logic [63:0] out_key;
    logic [1:0]  status;
    modport source (output valid, hit, evicted, promoted, out_key, status, input ready);
    modport sink   (input valid, hit, evicted, promoted, out_key, status, output ready);
endinterface

interface frc_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] clear_depth;
    modport source (output valid, clear_depth, input ready);
    modport sink   (input valid, clear_depth, output ready);
endinterface

// File: rtl/frc_ram.sv
// ----------------------------------------------------------------------------
// frc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module frc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: rtl/fifo_reinsertion_with_clear_point_core.sv
// ----------------------------------------------------------------------------
// fifo_reinsertion_with_clear_point_core
// FIFO reinsertion eviction policy with a reference bit clear point.
// ----------------------------------------------------------------------------
// One word is taken at a time, and the input is ready only while the block is
// idle. A lookup walks the ring from the front through the key RAM, one entry
// per cycle, and stops at the first match. An evict whose back entry has its
// reference bit set promotes it to the front instead. A full or empty error,
// or an unused code, goes straight to the result. The reference bit RAM has a
// single write port, so the clear point, the back entry and the new front are
// written in separate cycles. A result held by a stalled receiver holds the
// block in its last step. The reference bit RAM needs no clearing pass: every
// entry is written with a clear bit when it is pushed, before it can be read.
// Write the clear depth only while no word is in flight.
module fifo_reinsertion_with_clear_point_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frc_cfg_if.sink    i_cfg,
    frc_req_if.sink    i_in,
    frc_res_if.source  o_out
);

    frc_pkg::t_state r_state, n_state;

    logic [frc_pkg::CFG_W-1:0]    r_cd, n_cd;
    frc_pkg::t_addr               r_front, n_front;
    frc_pkg::t_occ                r_occ, n_occ;
    logic [frc_pkg::KEY_BITS-1:0] r_key, n_key;
    logic                         r_mark, n_mark;

    frc_pkg::t_occ  r_iss, n_iss;
    frc_pkg::t_addr r_ptr, n_ptr;
    logic           r_pend, n_pend;
    frc_pkg::t_addr r_paddr, n_paddr;

    logic           r_hit, n_hit;
    logic           r_ev, n_ev;
    logic           r_pr, n_pr;
    logic [1:0]     r_stat, n_stat;

    logic                 r_ov, n_ov;
    logic                 r_o_hit, n_o_hit;
    logic                 r_o_ev, n_o_ev;
    logic                 r_o_pr, n_o_pr;
    logic [63:0]          r_o_key, n_o_key;
    logic [1:0]           r_o_stat, n_o_stat;

    // RAM ports
    frc_pkg::t_addr               raddr;
    logic                         key_we;
    frc_pkg::t_addr               key_waddr;
    logic [frc_pkg::KEY_BITS-1:0] key_wdata;
    logic [frc_pkg::KEY_BITS-1:0] key_rdata;
    logic                         ref_we;
    frc_pkg::t_addr               ref_waddr;
    logic                         ref_wdata;
    logic                         ref_rdata;

    logic           clr_en;
    frc_pkg::t_addr clr_slot;
    frc_pkg::t_addr back_slot;
    frc_pkg::t_addr prev_slot;
    logic           out_free;

    frc_ram #(.WIDTH(frc_pkg::KEY_BITS), .DEPTH(frc_pkg::DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    frc_ram #(.WIDTH(1), .DEPTH(frc_pkg::DEPTH)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (ref_wdata),
        .i_raddr (raddr),
        .o_rdata (ref_rdata)
    );

    assign i_cfg.ready    = 1'b1;
    assign i_in.ready     = (r_state == frc_pkg::S_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.hit      = r_o_hit;
    assign o_out.evicted  = r_o_ev;
    assign o_out.promoted = r_o_pr;
    assign o_out.out_key  = r_o_key;
    assign o_out.status   = r_o_stat;

    assign out_free  = !r_ov || o_out.ready;
    assign clr_en    = (r_cd != '0) && (32'(r_occ) >= 32'(r_cd));
    assign clr_slot  = frc_pkg::slot_add(r_front, frc_pkg::t_occ'(r_cd - 10'd1));
    assign back_slot = frc_pkg::slot_add(r_front, r_occ - frc_pkg::t_occ'(1));
    assign prev_slot = frc_pkg::slot_prev(r_front);

    always_comb begin
        n_state  = r_state;
        n_cd     = r_cd;
        n_front  = r_front;
        n_occ    = r_occ;
        n_key    = r_key;
        n_mark   = r_mark;
        n_iss    = r_iss;
        n_ptr    = r_ptr;
        n_pend   = 1'b0;
        n_paddr  = r_paddr;
        n_hit    = r_hit;
        n_ev     = r_ev;
        n_pr     = r_pr;
        n_stat   = r_stat;
        n_ov     = r_ov && !o_out.ready;
        n_o_hit  = r_o_hit;
        n_o_ev   = r_o_ev;
        n_o_pr   = r_o_pr;
        n_o_key  = r_o_key;
        n_o_stat = r_o_stat;
        raddr     = back_slot;
        key_we    = 1'b0;
        key_waddr = prev_slot;
        key_wdata = r_key;
        ref_we    = 1'b0;
        ref_waddr = prev_slot;
        ref_wdata = 1'b0;

        if (i_cfg.valid) begin
            n_cd = i_cfg.clear_depth;
        end

        case (r_state)
            frc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_key  = i_in.key[frc_pkg::KEY_BITS-1:0];
                    n_mark = i_in.mark_on_hit;
                    n_hit  = 1'b0;
                    n_ev   = 1'b0;
                    n_pr   = 1'b0;
                    n_stat = frc_pkg::STAT_OK;
                    n_iss  = '0;
                    n_ptr  = r_front;
                    case (i_in.operation)
                        frc_pkg::OP_LOOKUP: n_state = frc_pkg::S_LK_RUN;
                        frc_pkg::OP_INSERT: begin
                            if (r_occ >= frc_pkg::t_occ'(frc_pkg::DEPTH)) begin
                                n_stat  = frc_pkg::STAT_FULL;
                                n_state = frc_pkg::S_DONE;
                            end else begin
                                n_state = frc_pkg::S_INS_A;
                            end
                        end
                        frc_pkg::OP_EVICT: begin
                            if (r_occ == '0) begin
                                n_stat  = frc_pkg::STAT_EMPTY;
                                n_state = frc_pkg::S_DONE;
                            end else begin
                                n_state = frc_pkg::S_EV_RD;
                            end
                        end
                        default: n_state = frc_pkg::S_DONE;
                    endcase
                end
            end
            frc_pkg::S_LK_RUN: begin
                if (r_pend && (key_rdata == r_key)) begin
                    n_hit = 1'b1;
                    if (r_mark) begin
                        ref_we    = 1'b1;
                        ref_waddr = r_paddr;
                        ref_wdata = 1'b1;
                    end
                    n_state = frc_pkg::S_DONE;
                end else if (r_iss != r_occ) begin
                    // issue the next read; the compare follows in the next cycle
                    raddr   = r_ptr;
                    n_pend  = 1'b1;
                    n_paddr = r_ptr;
                    n_ptr   = frc_pkg::slot_add(r_ptr, frc_pkg::t_occ'(1));
                    n_iss   = r_iss + frc_pkg::t_occ'(1);
                end else if (!r_pend) begin
                    n_state = frc_pkg::S_DONE;
                end
            end
            frc_pkg::S_INS_A: begin
                key_we    = 1'b1;
                ref_we    = clr_en;
                ref_waddr = clr_slot;
                n_state   = frc_pkg::S_INS_B;
            end
            frc_pkg::S_INS_B: begin
                ref_we  = 1'b1;
                n_front = prev_slot;
                n_occ   = r_occ + frc_pkg::t_occ'(1);
                n_state = frc_pkg::S_DONE;
            end
            frc_pkg::S_EV_RD: begin
                raddr   = back_slot;
                n_state = frc_pkg::S_EV_CHK;
            end
            frc_pkg::S_EV_CHK: begin
                n_key = key_rdata;
                if (!ref_rdata) begin
                    n_ev    = 1'b1;
                    n_occ   = r_occ - frc_pkg::t_occ'(1);
                    n_state = frc_pkg::S_DONE;
                end else begin
                    n_pr    = 1'b1;
                    n_state = frc_pkg::S_PR_A;
                end
            end
            frc_pkg::S_PR_A: begin
                // reinsert the promoted key at the front
                key_we    = 1'b1;
                ref_we    = clr_en;
                ref_waddr = clr_slot;
                n_state   = frc_pkg::S_PR_B;
            end
            frc_pkg::S_PR_B: begin
                ref_we    = 1'b1;
                ref_waddr = back_slot;
                n_state   = frc_pkg::S_PR_C;
            end
            frc_pkg::S_PR_C: begin
                ref_we  = 1'b1;
                n_front = prev_slot;
                n_state = frc_pkg::S_DONE;
            end
            frc_pkg::S_DONE: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_o_hit  = r_hit;
                    n_o_ev   = r_ev;
                    n_o_pr   = r_pr;
                    n_o_key  = (r_ev || r_pr) ? 64'(r_key) : '0;
                    n_o_stat = r_stat;
                    n_state  = frc_pkg::S_IDLE;
                end
            end
            default: n_state = frc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frc_pkg::S_IDLE;
            r_cd    <= frc_pkg::CLEAR_DEPTH_RST;
            r_front <= '0;
            r_occ   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cd    <= n_cd;
            r_front <= n_front;
            r_occ   <= n_occ;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_mark   <= n_mark;
        r_iss    <= n_iss;
        r_ptr    <= n_ptr;
        r_paddr  <= n_paddr;
        r_hit    <= n_hit;
        r_ev     <= n_ev;
        r_pr     <= n_pr;
        r_stat   <= n_stat;
        r_o_hit  <= n_o_hit;
        r_o_ev   <= n_o_ev;
        r_o_pr   <= n_o_pr;
        r_o_key  <= n_o_key;
        r_o_stat <= n_o_stat;
    end

endmodule
